@@ sv/xsfb_pkg.sv @@
// ----------------------------------------------------------------------------
// xsfb_pkg: shared definitions for the XOR sprite row frame store
// Screen geometry, request and register codes and the controller/datapath
// handshake structs.
// ----------------------------------------------------------------------------
package xsfb_pkg;

    // Screen geometry
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;

    localparam int ROW_AW   = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int COL_AW   = $clog2(SCREEN_WIDTH);
    localparam int COORD_W  = 8;
    localparam int SPRITE_W = 8;

    // Stream widths
    localparam int REQ_W     = 2;
    localparam int S_TDATA_W = 24;
    localparam int OUT_PIX_W = 64;
    localparam int M_TDATA_W = 72;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_DRAW  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_WRAP_H = 1'b0;
    localparam logic CFG_WRAP_V = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // capture the input word and read its row
        logic exec;     // modify/write the row and load the output word
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy; // output register holds a word that is not taken
    } t_dp_stat;

endpackage

@@ sv/xsfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// xsfb_ctrl: request sequencer
// Accepts one word, lets the datapath read its row, then runs the
// read-modify-write once the output register is free.
// ----------------------------------------------------------------------------
module xsfb_ctrl
    import xsfb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.exec   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.out_busy) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/xsfb_dp.sv @@
// ----------------------------------------------------------------------------
// xsfb_dp: frame store datapath
// Row memory with per-row valid bits, sprite mask build, collision check,
// wrap registers and the output word register.
// ----------------------------------------------------------------------------
module xsfb_dp
    import xsfb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [COORD_W-1:0]   i_start_column,
    input  logic [COORD_W-1:0]   i_row_index,
    input  logic [SPRITE_W-1:0]  i_sprite_bits,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic                 i_cfg_wdata,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [M_TDATA_W-1:0] o_out_data
);

    logic [SCREEN_WIDTH-1:0]  r_mem [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] r_row_vld;

    logic                     r_wrap_h;
    logic                     r_wrap_v;

    logic [REQ_W-1:0]         r_req;
    logic [COORD_W-1:0]       r_col;
    logic [COL_AW-1:0]        r_col_base;
    logic [SPRITE_W-1:0]      r_sprite;
    logic [ROW_AW-1:0]        r_row;
    logic                     r_row_on;
    logic [SCREEN_WIDTH-1:0]  r_rd_data;
    logic                     r_rd_vld;

    logic                     r_out_valid;
    logic [M_TDATA_W-1:0]     r_out_data;
    logic [M_TDATA_W-1:0]     n_out_data;

    logic [ROW_AW-1:0]        row_addr;
    logic [SCREEN_WIDTH-1:0]  line;
    logic [SCREEN_WIDTH-1:0]  mask;
    logic                     do_draw;
    logic                     hit;

    // Row address, always folded into the screen height
    assign row_addr = ROW_AW'(i_row_index % COORD_W'(SCREEN_HEIGHT));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_h <= 1'b0;
            r_wrap_v <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WRAP_H: r_wrap_h <= i_cfg_wdata;
                CFG_WRAP_V: r_wrap_v <= i_cfg_wdata;
            endcase
        end
    end

    // Capture the request and read its row
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req      <= i_req_type;
            r_col      <= i_start_column;
            r_col_base <= COL_AW'(i_start_column % COORD_W'(SCREEN_WIDTH));
            r_sprite   <= i_sprite_bits;
            r_row      <= row_addr;
            r_row_on   <= (i_row_index < 8'(SCREEN_HEIGHT)) | r_wrap_v;
            r_rd_data  <= r_mem[row_addr];
            r_rd_vld   <= r_row_vld[row_addr];
        end
    end

    // Rows never written since the last clear read as blank
    assign line = r_rd_vld ? r_rd_data : '0;

    // Build the sprite mask, one lane per sprite pixel
    always_comb begin
        logic [8:0]        x_raw;
        logic [COL_AW:0]   x_wrap;
        logic [COL_AW-1:0] pos;
        logic              en;
        mask = '0;
        for (int k = 0; k < SPRITE_W; k++) begin
            x_raw  = {1'b0, r_col} + 9'(k);
            x_wrap = {1'b0, r_col_base} + (COL_AW+1)'(k);
            if (x_wrap >= (COL_AW+1)'(SCREEN_WIDTH)) begin
                x_wrap = x_wrap - (COL_AW+1)'(SCREEN_WIDTH);
            end
            if (r_wrap_h) begin
                en  = 1'b1;
                pos = x_wrap[COL_AW-1:0];
            end else begin
                en  = (x_raw < 9'(SCREEN_WIDTH));
                pos = x_raw[COL_AW-1:0];
            end
            if (en && r_sprite[SPRITE_W-1-k]) begin
                mask[pos] = 1'b1;
            end
        end
    end

    assign do_draw = (r_req == REQ_DRAW) && r_row_on;
    assign hit     = |(line & mask);

    // Write back the drawn row
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_draw) begin
            r_mem[r_row] <= line ^ mask;
        end
    end

    // Row valid bits: reset and clear blank the whole screen at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.exec) begin
            if (r_req == REQ_CLEAR) begin
                r_row_vld <= '0;
            end else if (do_draw) begin
                r_row_vld[r_row] <= 1'b1;
            end
        end
    end

    // Result word: collision in bit 0, row pixels above
    always_comb begin
        n_out_data    = '0;
        n_out_data[0] = do_draw & hit;
        if (r_req == REQ_READ) begin
            n_out_data[OUT_PIX_W:1] = OUT_PIX_W'(line);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_stat.out_busy = r_out_valid & ~i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

@@ sv/xor_sprite_row_framebuffer_top.sv @@
// ----------------------------------------------------------------------------
// xor_sprite_row_framebuffer_top: monochrome XOR sprite frame store
// Flow: an accepted word is captured and its row read from the row memory;
// then, once the output register is free, a draw writes the row back and the
// result word is loaded. No new word is accepted until that is done.
// Reset: synchronous, clears the row valid bits (screen blank), the wrap
// registers and the output valid; ready for a word right after reset.
// ----------------------------------------------------------------------------
module xor_sprite_row_framebuffer_top
    import xsfb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // start_column, row_index, sprite_bits
    input  logic [REQ_W-1:0]     s_axis_tuser,   // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // collision, row_pixels, zero pad
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic                 i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    xsfb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    xsfb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_req_type     (s_axis_tuser),
        .i_start_column (s_axis_tdata[7:0]),
        .i_row_index    (s_axis_tdata[15:8]),
        .i_sprite_bits  (s_axis_tdata[23:16]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_data     (m_axis_tdata)
    );

endmodule

@@ sv/xsfb_checker.sv @@
// ----------------------------------------------------------------------------
// xsfb_checker: port-level checks for the frame store
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module xsfb_checker
    import xsfb_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // Drop the output word on reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // Take one word at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accepting a word");

    // Report collision only on draws, which return no pixels
    a_coll_no_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[OUT_PIX_W:1] == '0)
        else $error("collision word carries row pixels");

endmodule

bind xor_sprite_row_framebuffer_top xsfb_checker u_xsfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_xor_sprite_row_framebuffer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xor_sprite_row_framebuffer_top: self-checking bench for the XOR frame store
// Drives draw, clear, read and unused-code words into the slave stream,
// with random sender gaps and receiver stalls. A shadow copy of the screen
// predicts every output word, which is checked field by field in arrival order.
// The wrap registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
import xsfb_pkg::*;

typedef struct {
    logic                    collision;
    logic [SCREEN_WIDTH-1:0] pixels;
} t_draw_result;

class frame_shadow;
    logic [SCREEN_WIDTH-1:0] rows [SCREEN_HEIGHT];
    logic                    wrap_h;
    logic                    wrap_v;
    t_draw_result            due_results [$];
    int                      errors;

    function new();
        foreach (rows[i]) rows[i] = '0;
        wrap_h = 1'b0;
        wrap_v = 1'b0;
        errors = 0;
    endfunction

    function void set_wrap(logic idx, logic val);
        if (idx == CFG_WRAP_H) begin
            wrap_h = val;
        end else begin
            wrap_v = val;
        end
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    // XOR one sprite row into the shadow screen and return the hit flag
    function logic xor_sprite(logic [7:0] col, logic [7:0] row, logic [7:0] spr);
        int                      r;
        int                      x;
        logic                    hit;
        logic [SCREEN_WIDTH-1:0] bits;
        hit = 1'b0;
        r = row;
        if (r >= SCREEN_HEIGHT) begin
            if (!wrap_v) return 1'b0;
            r = r % SCREEN_HEIGHT;
        end
        bits = rows[r];
        for (int k = 0; k < 8; k++) begin
            x = int'(col) + k;
            if (x >= SCREEN_WIDTH && !wrap_h) break;
            if (spr[7-k]) begin
                if (bits[x % SCREEN_WIDTH]) hit = 1'b1;
                bits[x % SCREEN_WIDTH] = ~bits[x % SCREEN_WIDTH];
            end
        end
        rows[r] = bits;
        return hit;
    endfunction

    // Predict the result of one accepted request word
    function void note_request(logic [1:0] req, logic [7:0] col, logic [7:0] row,
                               logic [7:0] spr);
        t_draw_result res;
        res.collision = 1'b0;
        res.pixels    = '0;
        if (req == REQ_DRAW) begin
            res.collision = xor_sprite(col, row, spr);
        end else if (req == REQ_CLEAR) begin
            foreach (rows[i]) rows[i] = '0;
        end else if (req == REQ_READ) begin
            res.pixels = rows[int'(row) % SCREEN_HEIGHT];
        end
        due_results.push_back(res);
    endfunction

    // Compare one output word with the oldest prediction
    function void check_word(logic [M_TDATA_W-1:0] word);
        t_draw_result exp_res;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected output word %h", $time, word);
            errors++;
            return;
        end
        exp_res = due_results.pop_front();
        if (word[0] !== exp_res.collision) begin
            $display("%0t: collision mismatch expected %0d actual %0d",
                     $time, exp_res.collision, word[0]);
            errors++;
        end
        if (word[OUT_PIX_W:1] !== exp_res.pixels) begin
            $display("%0t: row_pixels mismatch expected %h actual %h",
                     $time, exp_res.pixels, word[OUT_PIX_W:1]);
            errors++;
        end
    endfunction
endclass

module tb_xor_sprite_row_framebuffer_top;

    localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;
    localparam int               CYCLE_LIMIT = 500000;
    localparam int               PHASE_WORDS = 250;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [REQ_W-1:0]     s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_index = 1'b0;
    logic                 i_cfg_wdata = 1'b0;

    frame_shadow screen = new();
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int          cycles = 0;

    xor_sprite_row_framebuffer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one request word and hold it until accepted
    task automatic send_word(logic [1:0] req, logic [7:0] col, logic [7:0] row,
                             logic [7:0] spr);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {spr, row, col};
        do @(posedge i_clk); while (!s_axis_tready);
        screen.note_request(req, col, row, spr);
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (screen.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        screen.set_wrap(idx, val);
    endtask

    function automatic logic [7:0] pick_col();
        return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, SCREEN_WIDTH - 1))
                                          : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_row();
        return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, SCREEN_HEIGHT - 1))
                                          : 8'($urandom_range(0, 255));
    endfunction

    // Accept and check output words with random stalls
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            stall = rx_idle ? $urandom_range(0, 14) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            screen.check_word(m_axis_tdata);
        end
    end

    initial begin
        int         sent;
        int         n;
        int         pick;
        logic [7:0] col;
        logic [7:0] row;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no wrap, edges and off-screen cases
        cfg_write(CFG_WRAP_H, 1'b0);
        cfg_write(CFG_WRAP_V, 1'b0);
        send_word(REQ_READ,  8'd0,   8'd0,   8'h00);
        send_word(REQ_DRAW,  8'd0,   8'd0,   8'hFF);
        send_word(REQ_DRAW,  8'd0,   8'd0,   8'h81);
        send_word(REQ_READ,  8'd0,   8'd0,   8'h00);
        send_word(REQ_DRAW,  8'd60,  8'd31,  8'hFF);
        send_word(REQ_DRAW,  8'd64,  8'd5,   8'hFF);
        send_word(REQ_DRAW,  8'd255, 8'd5,   8'hFF);
        send_word(REQ_DRAW,  8'd0,   8'd32,  8'hFF);
        send_word(REQ_DRAW,  8'd3,   8'd255, 8'hFF);
        send_word(REQ_READ,  8'd0,   8'd31,  8'h00);
        send_word(REQ_READ,  8'd0,   8'd32,  8'h00);
        send_word(REQ_READ,  8'hFF,  8'd255, 8'hFF);
        send_word(REQ_UNUSED, 8'hFF, 8'hFF,  8'hFF);
        send_word(REQ_CLEAR, 8'hFF,  8'hFF,  8'hFF);
        send_word(REQ_READ,  8'd0,   8'd31,  8'h00);
        drain();

        // Directed: both wraps on
        cfg_write(CFG_WRAP_H, 1'b1);
        cfg_write(CFG_WRAP_V, 1'b1);
        send_word(REQ_DRAW, 8'd60,  8'd31, 8'hFF);
        send_word(REQ_DRAW, 8'd255, 8'd63, 8'h80);
        send_word(REQ_DRAW, 8'd62,  8'd32, 8'h01);
        send_word(REQ_DRAW, 8'd10,  8'd1,  8'h00);
        send_word(REQ_READ, 8'd0,   8'd31, 8'h00);
        send_word(REQ_READ, 8'd0,   8'd0,  8'h00);
        send_word(REQ_READ, 8'd0,   8'd65, 8'h00);
        drain();

        // Random phases, each under its own wrap setting
        for (int p = 0; p < 8; p++) begin
            cfg_write(CFG_WRAP_H, (p < 4) ? p[0] : 1'($urandom_range(0, 1)));
            cfg_write(CFG_WRAP_V, (p < 4) ? p[1] : 1'($urandom_range(0, 1)));
            sent = 0;
            while (sent < PHASE_WORDS) begin
                if (sent % 50 == 0) begin
                    tx_idle = ($urandom_range(0, 2) != 0);
                    rx_idle = ($urandom_range(0, 2) != 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    // Sprite draw: consecutive rows, then at random read them back
                    n   = $urandom_range(1, 15);
                    col = pick_col();
                    row = pick_row();
                    for (int i = 0; i < n; i++) begin
                        send_word(REQ_DRAW, col, 8'(row + i), 8'($urandom));
                    end
                    sent += n;
                    if ($urandom_range(0, 1)) begin
                        for (int i = 0; i < n; i++) begin
                            send_word(REQ_READ, 8'($urandom), 8'(row + i), 8'($urandom));
                        end
                        sent += n;
                    end
                end else if (pick < 85) begin
                    send_word(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                              8'($urandom));
                    sent++;
                end else if (pick < 97) begin
                    send_word(REQ_READ, 8'($urandom), pick_row(), 8'($urandom));
                    sent++;
                end else if (pick < 99) begin
                    send_word(REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
                    sent++;
                end else begin
                    drain();
                end
            end
            drain();
        end

        // Let the pipe settle, then report
        tx_idle = 1'b0;
        repeat (6) @(posedge i_clk);
        if (screen.errors == 0 && screen.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
